/* sv/besa_pkg.sv */
// Shared types and constants for the begin/end statistics accumulator.
// Used by every module of the block; depends on nothing else.
package besa_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;
  localparam int MODE_W = 2;
  localparam int ERR_W  = 3;

  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_BEGIN = 2'd0,
    MODE_END   = 2'd1,
    MODE_ASIS  = 2'd2,
    MODE_BAD   = 2'd3
  } mode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK            = 3'd0,
    ERR_BEGIN_PENDING = 3'd1,
    ERR_NO_START      = 3'd2,
    ERR_END_BELOW     = 3'd3,
    ERR_MIXED         = 3'd4,
    ERR_BAD_MODE      = 3'd5
  } err_t;

  // Decoded item: the value to accumulate and whether it counts.
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              acc;
    err_t              err;
  } s1_pkt_t;

  // Square partial products: low half squared and the low bits of low*high.
  typedef struct packed {
    logic [WORD_W-1:0] sq_lo;
    logic [HALF_W-1:0] sq_cross;
    logic              acc;
    err_t              err;
  } s2_pkt_t;

  typedef struct packed {
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] vmin;
    logic [WORD_W-1:0] vmax;
  } stats_t;

endpackage

/* sv/besa_decode.sv */
// First stage: checks the mode against the pending start reading and
// produces the value to accumulate. Depends on besa_pkg.
module besa_decode
  import besa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  mode_t             mode,
  input  logic [WORD_W-1:0] sample,
  output s1_pkt_t           pkt_r
);

  logic              pending_r, pending_nxt;
  logic [WORD_W-1:0] start_r, start_nxt;
  logic [WORD_W:0]   diff_ext;
  s1_pkt_t           pkt_nxt;

  // The borrow out of the wide subtraction flags an end below its start.
  assign diff_ext = {1'b0, sample} - {1'b0, start_r};

  always_comb begin
    pending_nxt   = pending_r;
    start_nxt     = start_r;
    pkt_nxt.value = sample;
    pkt_nxt.acc   = 1'b0;
    pkt_nxt.err   = ERR_OK;
    unique case (mode)
      MODE_BEGIN: begin
        if (pending_r) begin
          pkt_nxt.err = ERR_BEGIN_PENDING;
        end else begin
          pending_nxt = 1'b1;
          start_nxt   = sample;
        end
      end
      MODE_END: begin
        if (!pending_r) begin
          pkt_nxt.err = ERR_NO_START;
        end else if (diff_ext[WORD_W]) begin
          pkt_nxt.err = ERR_END_BELOW;
        end else begin
          pending_nxt   = 1'b0;
          pkt_nxt.acc   = 1'b1;
          pkt_nxt.value = diff_ext[WORD_W-1:0];
        end
      end
      MODE_ASIS: begin
        if (pending_r || (start_r != '0)) begin
          pkt_nxt.err = ERR_MIXED;
        end else begin
          pkt_nxt.acc = 1'b1;
        end
      end
      default: begin
        pkt_nxt.err = ERR_BAD_MODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      start_r   <= '0;
    end else if (load) begin
      pending_r <= pending_nxt;
      start_r   <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_r <= pkt_nxt;
    end
  end

`ifndef SYNTH
  // A rejected item must never reach the accumulators.
  a_acc_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_r.acc |-> (pkt_r.err == ERR_OK))
    else $error("decode marked an erroneous item for accumulation");

  // An accepted end item always clears the pending start.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load && (mode == MODE_END) && pkt_nxt.acc |=> !pending_r)
    else $error("accepted end left a start pending");
`endif

endmodule

/* sv/besa_accum.sv */
// Second stage: count, sum, minimum and maximum accumulators, and the two
// partial products of the square, 64 and 32 bits wide. Depends on besa_pkg.
module besa_accum
  import besa_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  s1_pkt_t pkt,
  output s2_pkt_t pkt_r,
  output stats_t  stats_r
);

  logic [HALF_W-1:0] lo_half;
  logic [HALF_W-1:0] hi_half;
  s2_pkt_t           pkt_nxt;
  stats_t            stats_nxt;

  assign lo_half = pkt.value[HALF_W-1:0];
  assign hi_half = pkt.value[WORD_W-1:HALF_W];

  // Only the low word of the square is kept, so the high*high term drops
  // out and the cross term needs just its low half.
  always_comb begin
    pkt_nxt.sq_lo    = {{HALF_W{1'b0}}, lo_half} * {{HALF_W{1'b0}}, lo_half};
    pkt_nxt.sq_cross = lo_half * hi_half;
    pkt_nxt.acc      = pkt.acc;
    pkt_nxt.err      = pkt.err;
  end

  always_comb begin
    stats_nxt      = stats_r;
    stats_nxt.cnt  = stats_r.cnt + WORD_W'(1);
    stats_nxt.sum  = stats_r.sum + pkt.value;
    if (pkt.value < stats_r.vmin) begin
      stats_nxt.vmin = pkt.value;
    end
    if (pkt.value > stats_r.vmax) begin
      stats_nxt.vmax = pkt.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r.cnt  <= '0;
      stats_r.sum  <= '0;
      stats_r.vmin <= WORD_MAX;
      stats_r.vmax <= '0;
    end else if (load && pkt.acc) begin
      stats_r <= stats_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_r <= pkt_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_step: assert property (@(posedge clk)
    rst_n && $past(rst_n) |->
      (stats_r.cnt == $past(stats_r.cnt)) ||
      (stats_r.cnt == $past(stats_r.cnt) + WORD_W'(1)))
    else $error("sample count moved by more than one");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (stats_r.cnt != '0) |-> (stats_r.vmin <= stats_r.vmax))
    else $error("minimum above maximum after accumulation");
`endif

endmodule

/* sv/besa_square.sv */
// Third stage: sum of squares accumulator and the result register.
// Depends on besa_pkg.
module besa_square
  import besa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  s2_pkt_t           pkt,
  input  stats_t            stats,
  output stats_t            out_stats_r,
  output logic [WORD_W-1:0] sq_sum_r,
  output err_t              out_err_r
);

  logic [WORD_W-1:0] sq_sum_nxt;

  // square mod 2^64 = lo*lo + 2*(lo*hi mod 2^32) * 2^32
  assign sq_sum_nxt = sq_sum_r + pkt.sq_lo
                    + {pkt.sq_cross[HALF_W-2:0], {(HALF_W+1){1'b0}}};

  // The accumulator changes only when the result register loads, so it
  // doubles as the square_sum field of the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_sum_r <= '0;
    end else if (load && pkt.acc) begin
      sq_sum_r <= sq_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_stats_r <= stats;
      out_err_r   <= pkt.err;
    end
  end

endmodule

/* sv/begin_end_statistics_accumulator_unit.sv */
// Begin/end statistics accumulator, top level with stream ports.
// Stages, all registered: decode, accumulate with square partial products,
// and square sum with result. Throughput: one item per cycle while results
// are taken without a stall; each stage holds one item and advances whenever
// the stage after it is empty or moving, so bubbles are squeezed out.
// Reset (rst_n low, synchronous) empties the pipeline, clears the pending start
// and all sums, and sets the minimum to all ones.
module begin_end_statistics_accumulator_unit
  import besa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [WORD_W-1:0]   in_tdata,   // [63:0] sample_value
  input  logic [MODE_W-1:0]   in_tuser,   // [1:0] mode
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [5*WORD_W-1:0] out_tdata,  // [63:0] sample_count, [127:64] value_sum,
                                          // [191:128] value_min, [255:192] value_max,
                                          // [319:256] square_sum
  output logic [ERR_W-1:0]    out_tuser   // [2:0] error_code
);

  logic    s1_v_r, s2_v_r, out_v_r;
  logic    out_free, s2_mv, s2_free, s1_mv, in_acc;
  s1_pkt_t s1_pkt;
  s2_pkt_t s2_pkt;
  stats_t  acc_stats;
  stats_t  out_stats;
  logic [WORD_W-1:0] sq_sum;
  err_t    out_err;

  // Each stage moves forward when its successor has room this cycle.
  assign out_free  = !out_v_r || out_tready;
  assign s2_mv     = s2_v_r && out_free;
  assign s2_free   = !s2_v_r || s2_mv;
  assign s1_mv     = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s1_mv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (out_free) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Mode checks and start tracking happen as the item is accepted.
  besa_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc),
    .mode   (mode_t'(in_tuser)),
    .sample (in_tdata),
    .pkt_r  (s1_pkt)
  );

  // Count, sum, min and max update as the item leaves the first stage.
  besa_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (s1_mv),
    .pkt     (s1_pkt),
    .pkt_r   (s2_pkt),
    .stats_r (acc_stats)
  );

  // The sum of squares and the result register load together; the
  // statistics snapshot taken here already includes this item.
  besa_square u_square (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s2_mv),
    .pkt         (s2_pkt),
    .stats       (acc_stats),
    .out_stats_r (out_stats),
    .sq_sum_r    (sq_sum),
    .out_err_r   (out_err)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {sq_sum, out_stats.vmax, out_stats.vmin, out_stats.sum, out_stats.cnt};
  assign out_tuser  = out_err;

`ifndef SYNTH
  // Input can only be held off by a full pipeline behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s2_v_r && out_v_r && !out_tready))
    else $error("input stalled while the pipeline had room");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for begin_end_statistics_accumulator_unit.
// Drives begin/end/as-is samples over the input stream and checks every result
// against a cycle-free prediction of the statistics; depends on besa_pkg and the unit.
module tb_top
  import besa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no handshake on either channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_PRINTED    = 20;

  // One expected result: the statistics after the item plus its error code.
  typedef struct packed {
    logic [WORD_W-1:0] cnt;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] vmin;
    logic [WORD_W-1:0] vmax;
    logic [WORD_W-1:0] sqs;
    err_t              err;
  } stats_result_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [WORD_W-1:0]   in_tdata   = '0;
  logic [MODE_W-1:0]   in_tuser   = MODE_BAD;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [5*WORD_W-1:0] out_tdata;
  logic [ERR_W-1:0]    out_tuser;

  // Predicted state of the accumulator.
  logic              start_held;
  logic [WORD_W-1:0] start_word;
  logic [WORD_W-1:0] acc_count;
  logic [WORD_W-1:0] acc_sum;
  logic [WORD_W-1:0] acc_min;
  logic [WORD_W-1:0] acc_max;
  logic [WORD_W-1:0] acc_squares;

  stats_result_t pending_stats_q[$];

  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int hold_cycles_left  = 0;
  int items_sent        = 0;
  int results_checked   = 0;
  int fail_count        = 0;
  int err_seen[6];

  begin_end_statistics_accumulator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Prints one line per failure (up to a cap) and counts all of them.
  task automatic report_failure(string msg);
    if (fail_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  task automatic clear_stats_model();
    start_held  = 1'b0;
    start_word  = '0;
    acc_count   = '0;
    acc_sum     = '0;
    acc_min     = WORD_MAX;
    acc_max     = '0;
    acc_squares = '0;
  endtask

  // Applies one accepted item to the predicted state and queues the result
  // the block has to return for it. Any misuse leaves the state untouched.
  task automatic compute_stats(mode_t mode, logic [WORD_W-1:0] sample);
    stats_result_t     res;
    err_t              err;
    logic              take;
    logic [WORD_W-1:0] val;
    err  = ERR_OK;
    take = 1'b0;
    val  = sample;
    case (mode)
      MODE_BEGIN: begin
        if (start_held) begin
          err = ERR_BEGIN_PENDING;
        end else begin
          start_held = 1'b1;
          start_word = sample;
        end
      end
      MODE_END: begin
        if (!start_held) begin
          err = ERR_NO_START;
        end else if (sample < start_word) begin
          err = ERR_END_BELOW;
        end else begin
          // The start reading is kept; only the pending flag drops.
          start_held = 1'b0;
          val        = sample - start_word;
          take       = 1'b1;
        end
      end
      MODE_ASIS: begin
        // Direct values are only allowed while no start is pending and the start reading is zero.
        if (start_held || start_word != '0) begin
          err = ERR_MIXED;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        err = ERR_BAD_MODE;
      end
    endcase
    if (take) begin
      acc_count   = acc_count + 1'b1;
      acc_sum     = acc_sum + val;
      acc_squares = acc_squares + val * val;
      if (val < acc_min) acc_min = val;
      if (val > acc_max) acc_max = val;
    end
    res.cnt  = acc_count;
    res.sum  = acc_sum;
    res.vmin = acc_min;
    res.vmax = acc_max;
    res.sqs  = acc_squares;
    res.err  = err;
    pending_stats_q.push_back(res);
    err_seen[int'(err)]++;
  endtask

  // Offers one item at a falling edge, after random idle cycles, and holds it
  // until the block takes it. Valid stays high into the next item if no gap.
  task automatic send_item(mode_t mode, logic [WORD_W-1:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= sample;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compute_stats(mode, sample);
    items_sent++;
  endtask

  // Lowers valid and waits until every queued result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_stats_q.size() != 0) @(posedge clk);
  endtask

  // Random word biased toward the corners: zero, all ones, powers of two,
  // small values and values just below the top.
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(5))
      0: w = '0;
      1: w = WORD_MAX - WORD_W'($urandom_range(1000));
      2: w = 64'd1 << $urandom_range(63);
      3: w = WORD_W'($urandom_range(1000));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // One random sequence. Half are well-formed begin/end pairs so that the
  // accumulator keeps growing; some reopen as-is use with a begin of zero;
  // the rest is noise and broken sequences.
  task automatic send_random_sequence();
    logic [WORD_W-1:0] first;
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] last;
    int                pick;
    int                n;
    pick  = $urandom_range(99);
    first = rand_word();
    delta = ($urandom_range(1)) ? rand_word() : WORD_W'($urandom_range(5000));
    last  = first + delta;
    if (last < first) last = WORD_MAX;
    if (pick < 50) begin
      send_item(MODE_BEGIN, first);
      send_item(MODE_END, last);
    end else if (pick < 68) begin
      // A begin of zero with its end clears the way for direct values.
      send_item(MODE_BEGIN, '0);
      send_item(MODE_END, delta);
      n = $urandom_range(1, 4);
      repeat (n) send_item(MODE_ASIS, rand_word());
    end else if (pick < 78) begin
      // End below its start, then the proper end.
      send_item(MODE_BEGIN, last);
      if (last != '0) send_item(MODE_END, last - 1'b1 - (first % last));
      send_item(MODE_END, last);
    end else if (pick < 84) begin
      // Double begin.
      send_item(MODE_BEGIN, first);
      send_item(MODE_BEGIN, rand_word());
      send_item(MODE_END, last);
    end else begin
      send_item(mode_t'($urandom_range(3)), rand_word());
    end
  endtask

  // Short directed list: field extremes, every mode and every misuse.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(MODE_END,   64'd5);                 // end with no start
    send_item(MODE_BAD,   WORD_MAX);              // invalid mode
    send_item(MODE_ASIS,  '0);                    // zero sets the minimum
    send_item(MODE_ASIS,  WORD_MAX);              // square wraps
    send_item(MODE_ASIS,  64'h0000_0001_0000_0001);
    send_item(MODE_ASIS,  64'hAAAA_5555_F0F0_0F0F);
    send_item(MODE_BEGIN, '0);
    send_item(MODE_BEGIN, 64'd7);                 // begin while pending
    send_item(MODE_ASIS,  64'd3);                 // as-is while pending
    send_item(MODE_END,   '0);                    // zero difference
    send_item(MODE_ASIS,  64'd42);                // still allowed after a zero start
    send_item(MODE_BEGIN, 64'd100);
    send_item(MODE_END,   64'd99);                // end below start
    send_item(MODE_END,   64'd100);
    send_item(MODE_ASIS,  64'd1);                 // start reading left nonzero
    send_item(MODE_BAD,   '0);
    send_item(MODE_BEGIN, '0);
    send_item(MODE_END,   WORD_MAX);              // largest difference
    send_item(MODE_ASIS,  64'd5);
    send_item(MODE_BEGIN, WORD_MAX);
    send_item(MODE_END,   WORD_MAX);
    send_item(MODE_BEGIN, 64'd1);
    send_item(MODE_END,   '0);                    // below start of one
    send_item(MODE_END,   64'h5555_AAAA_0F0F_F0F0);
    wait_results_drained();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n_items;
    while (items_sent < target) send_random_sequence();
    wait_results_drained();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // pipeline fills and the input side has to stall.
  task automatic test_long_backpressure();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_cycles_left = 80;
    repeat (20) send_random_sequence();
    wait_results_drained();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles_left > 0) begin
        out_tready <= 1'b0;
        hold_cycles_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin : result_check
    stats_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stats_q.size() == 0) begin
        report_failure($sformatf("result with nothing expected, count %h",
                                 out_tdata[0 +: WORD_W]));
      end else begin
        want = pending_stats_q.pop_front();
        results_checked++;
        if (out_tdata[0*WORD_W +: WORD_W] !== want.cnt)
          report_failure($sformatf("sample_count got %h want %h",
                                   out_tdata[0*WORD_W +: WORD_W], want.cnt));
        if (out_tdata[1*WORD_W +: WORD_W] !== want.sum)
          report_failure($sformatf("value_sum got %h want %h",
                                   out_tdata[1*WORD_W +: WORD_W], want.sum));
        if (out_tdata[2*WORD_W +: WORD_W] !== want.vmin)
          report_failure($sformatf("value_min got %h want %h",
                                   out_tdata[2*WORD_W +: WORD_W], want.vmin));
        if (out_tdata[3*WORD_W +: WORD_W] !== want.vmax)
          report_failure($sformatf("value_max got %h want %h",
                                   out_tdata[3*WORD_W +: WORD_W], want.vmax));
        if (out_tdata[4*WORD_W +: WORD_W] !== want.sqs)
          report_failure($sformatf("square_sum got %h want %h",
                                   out_tdata[4*WORD_W +: WORD_W], want.sqs));
        if (out_tuser !== want.err)
          report_failure($sformatf("error_code got %0d want %0d", out_tuser, want.err));
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_stats_q.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    foreach (err_seen[i]) err_seen[i] = 0;
    clear_stats_model();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_phase(0, 0, 320);
    test_random_phase(71, 0, 320);
    test_long_backpressure();
    test_random_phase(0, 71, 320);
    test_random_phase(6, 6, 320);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d samples accumulated",
             items_sent, results_checked, acc_count);
    $display("summary: ok %0d, begin pending %0d, no start %0d, end below %0d,",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    $display("summary: mixed %0d, bad mode %0d", err_seen[4], err_seen[5]);
    if (fail_count == 0 && pending_stats_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/besa_pkg.sv
sv/besa_decode.sv
sv/besa_accum.sv
sv/besa_square.sv
sv/begin_end_statistics_accumulator_unit.sv
tb/sv/tb_top.sv
